// ===== rtl/core/sba_pkg.sv =====
package sba_pkg;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_REM = 3'd4
    } act_t;

    // Restoring-division steps done by each divider stage.
    localparam int DIV_STEPS = 4;

    typedef struct packed {
        logic [2:0]        action;
        logic signed [7:0] operand_a;
        logic signed [7:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [7:0] result;
        logic              div_by_zero;
    } rsp_t;

    // Everything one word carries between pipeline stages.
    typedef struct packed {
        logic       valid;
        act_t       action;
        logic       sign_a;
        logic       sign_b;
        logic       dz;
        logic [7:0] den;
        logic [7:0] num;
        logic [7:0] rem;
        logic [7:0] quo;
        logic [7:0] arith;
    } pipe_t;

endpackage

// ===== rtl/core/signed_byte_alu_top.sv =====
// Signed 8-bit ALU: add, subtract, multiply, divide and remainder.
// A command word (req) is taken at a rising edge where start is high and
// busy is low. busy never rises, so a new word may be issued every cycle.
// Each word yields one response word (rsp) that is shown for exactly one
// cycle with done high; the receiver cannot hold it off.
// The pipeline runs through operand preparation, two divider stages of four
// restoring steps each, and the sign-correction/select output register.
// Throughput is one word per cycle; the 4-stage pipeline sets the latency.
// Divide and remainder by zero give result 0 with div_by_zero set.
// Unused action codes give result 0 with div_by_zero clear.
// Reset clears all valid bits, so words in flight are dropped and done
// stays low until a new word has passed the pipeline.
module signed_byte_alu_top
    import sba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    pipe_t s1;
    pipe_t s2;
    pipe_t s3;

    assign busy = 1'b0;

    sba_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (start && !busy),
        .req       (req),
        .stage_out (s1)
    );

    sba_div_stage u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (s1),
        .stage_out (s2)
    );

    sba_div_stage u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (s2),
        .stage_out (s3)
    );

    sba_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (s3),
        .done     (done),
        .rsp      (rsp)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("accepted word did not complete after four cycles");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("response without a matching command");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.div_by_zero) |-> (rsp.result == 8'sd0))
        else $error("zero-divisor response carries a nonzero result");

    a_dz_action: assert property (@(posedge clk) disable iff (!rst_n)
        (start && ((req.action == ACT_ADD) || (req.action == ACT_SUB) ||
                   (req.action == ACT_MUL))) |-> ##4 !rsp.div_by_zero)
        else $error("div_by_zero raised for a non-divide operation");

endmodule

// ===== rtl/core/sba_prep.sv =====
module sba_prep
    import sba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  req_t  req,
    output pipe_t stage_out
);

    pipe_t      stage_reg;
    pipe_t      stage_next;
    logic [7:0] a_u;
    logic [7:0] b_u;
    logic [15:0] prod;

    always_comb
    begin
        a_u  = req.operand_a;
        b_u  = req.operand_b;
        // The low byte of the raw product equals the low byte of the signed product.
        prod = a_u * b_u;

        stage_next.valid  = load;
        stage_next.action = act_t'(req.action);
        stage_next.sign_a = a_u[7];
        stage_next.sign_b = b_u[7];
        stage_next.den    = b_u[7] ? 8'(-b_u) : b_u;
        stage_next.num    = a_u[7] ? 8'(-a_u) : a_u;
        stage_next.rem    = 8'd0;
        stage_next.quo    = 8'd0;
        stage_next.dz     = (b_u == 8'd0) &&
                            ((req.action == ACT_DIV) || (req.action == ACT_REM));
        case (act_t'(req.action))
            ACT_ADD: stage_next.arith = a_u + b_u;
            ACT_SUB: stage_next.arith = a_u - b_u;
            ACT_MUL: stage_next.arith = prod[7:0];
            default: stage_next.arith = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/core/sba_div_stage.sv =====
module sba_div_stage
    import sba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  pipe_t stage_in,
    output pipe_t stage_out
);

    pipe_t stage_reg;
    pipe_t stage_next;

    // Partial remainder stays below the divisor (at most 128), so
    // shifting in one bit never overflows eight bits.
    always_comb
    begin
        stage_next = stage_in;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            stage_next.rem = {stage_next.rem[6:0], stage_next.num[7]};
            stage_next.num = {stage_next.num[6:0], 1'b0};
            if (stage_next.rem >= stage_next.den)
            begin
                stage_next.rem = stage_next.rem - stage_next.den;
                stage_next.quo = {stage_next.quo[6:0], 1'b1};
            end
            else
            begin
                stage_next.quo = {stage_next.quo[6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/core/sba_finish.sv =====
module sba_finish
    import sba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  pipe_t stage_in,
    output logic  done,
    output rsp_t  rsp
);

    logic done_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    always_comb
    begin
        rsp_next.div_by_zero = stage_in.dz;
        case (stage_in.action)
            ACT_ADD, ACT_SUB, ACT_MUL:
                rsp_next.result = stage_in.arith;
            ACT_DIV:
                if (stage_in.dz)
                    rsp_next.result = 8'sd0;
                else if (stage_in.sign_a ^ stage_in.sign_b)
                    rsp_next.result = 8'(-stage_in.quo);
                else
                    rsp_next.result = stage_in.quo;
            ACT_REM:
                if (stage_in.dz)
                    rsp_next.result = 8'sd0;
                else if (stage_in.sign_a)
                    rsp_next.result = 8'(-stage_in.rem);
                else
                    rsp_next.result = stage_in.rem;
            default:
                rsp_next.result = 8'sd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
